// File: hdl/pqe_pkg.sv
`default_nettype none
package pqe_pkg;
  localparam int MAX_SUBSPACES_D  = 16;
  localparam int MAX_CENTROIDS_D  = 256;
  localparam int MAX_SUB_LENGTH_D = 8;
  localparam int SAMPLE_BITS_D    = 16;
  localparam int DIST_BITS        = 37;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  localparam logic [1:0] REG_SUBSPACES = 2'd0;
  localparam logic [1:0] REG_ELEMENTS  = 2'd1;
  localparam logic [1:0] REG_CENTROIDS = 2'd2;

  // running best carried along the cell row
  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [7:0]           idx;
  } best_t;
endpackage
`default_nettype wire

// File: hdl/pqe_cell.sv
`default_nettype none
module pqe_cell
  import pqe_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,     // sample enters this cell
  input  wire logic                 first,    // first element of a subspace
  input  wire logic                 enable,   // centroid lies inside centroid_count
  input  wire logic [7:0]           index,
  input  wire logic signed [16:0]   diff,
  input  wire best_t                best_in,
  input  wire logic                 tok_in,   // best_in is the live running best
  output best_t                     best_out,
  output logic                      tok_out
);
  logic [DIST_BITS-1:0] total;
  logic [33:0]          sq;

  assign sq = 34'(diff) * 34'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (step) begin
      total <= (first ? '0 : total) + DIST_BITS'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  // strict less keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (tok_in && enable && total < best_in.distance) begin
      best_out.distance <= total;
      best_out.idx      <= index;
    end else begin
      best_out <= best_in;
    end
  end
endmodule
`default_nettype wire

// File: hdl/product_quantizer_encoder.sv
// Product-quantization encoder.
// s_tvalid/s_tready/s_tdata carry requests: op 0 writes one codebook sample
// at (subspace, centroid, element); op 1 streams the next vector element.
// Each cell owns one centroid: its slice of the codebook and its distance sum.
// A vector element reads every cell's sample at the edge that accepts it, and
// the cells fold the squared difference into their sums on the next edge.
// After a subspace's last element a token carries the running best down the
// row, one cell per cycle; the code is then registered on m_tvalid/m_tready/
// m_tdata (code, subspace_index), with vector_done on m_tuser.
// The code is registered when the token leaves the last cell; the search of a
// subspace starts later if the previous code is still held.
// Throughput: one request per cycle; after a subspace's last element s_tready
// drops until its code is registered.
// A stalled receiver holds the code register; requests are still taken until
// the next subspace ends, whose search then waits for the output to free.
// Reset clears positions and sums and restores the register defaults; the
// codebook is undefined until written.
`default_nettype none
module product_quantizer_encoder
  import pqe_pkg::*;
#(
  parameter int MAX_CENTROIDS = MAX_CENTROIDS_D
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [0] operation, [4:1] load_subspace, [12:5] load_centroid,
  // [15:13] load_element, [31:16] element_value
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] code, [11:8] subspace_index
  output logic [15:0]      m_tdata,
  // [0] vector_done
  output logic             m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  localparam int RD = MAX_SUBSPACES_D * MAX_SUB_LENGTH_D;

  logic [4:0] subspace_count;
  logic [3:0] elements_per_subspace;
  logic [8:0] centroid_count;
  logic [2:0] element_position;
  logic [3:0] subspace_position;

  logic        op;
  logic [3:0]  ls;
  logic [7:0]  lc;
  logic [2:0]  le;
  logic signed [15:0] sample;
  assign op = s_tdata[0];
  assign ls = s_tdata[4:1];
  assign lc = s_tdata[12:5];
  assign le = s_tdata[15:13];
  assign sample = s_tdata[31:16];

  logic [4:0] subs;
  logic [3:0] eps;
  logic [8:0] cents;
  assign subs  = (subspace_count == 0) ? 5'd1 :
                 (subspace_count > 5'd16) ? 5'd16 : subspace_count;
  assign eps   = (elements_per_subspace == 0) ? 4'd1 :
                 (elements_per_subspace > 4'd8) ? 4'd8 : elements_per_subspace;
  assign cents = (centroid_count == 0) ? 9'd1 :
                 (centroid_count > 9'(MAX_CENTROIDS)) ? 9'(MAX_CENTROIDS) : centroid_count;

  logic searching;   // last element taken, code not yet registered
  logic running;     // token on its way down the row
  logic go;
  assign s_tready = !searching;

  logic acc, vec_acc, last_elem, last_sub;
  assign acc       = s_tvalid && s_tready;
  assign vec_acc   = acc && op == OP_VECTOR;
  assign last_elem = 4'(element_position) + 4'd1 >= eps;
  assign last_sub  = 5'(subspace_position) + 5'd1 >= subs;

  // stage 1: register the vector sample while cells read their memories
  logic        v1, first1;
  logic signed [15:0] x1;
  logic [6:0]  raddr;
  assign raddr = {subspace_position, element_position};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= vec_acc;
    end
    x1     <= sample;
    first1 <= element_position == 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      subspace_count        <= 5'd8;
      elements_per_subspace <= 4'd8;
      centroid_count        <= 9'd256;
      element_position      <= '0;
      subspace_position     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SUBSPACES: subspace_count        <= cfg_data[4:0];
          REG_ELEMENTS:  elements_per_subspace <= cfg_data[3:0];
          REG_CENTROIDS: centroid_count        <= cfg_data;
          default: ;
        endcase
      end
      if (vec_acc) begin
        if (last_elem) begin
          element_position  <= '0;
          subspace_position <= last_sub ? '0 : subspace_position + 4'd1;
        end else begin
          element_position <= element_position + 3'd1;
        end
      end
    end
  end

  // cell row: each cell owns one centroid's samples and distance
  best_t chain [MAX_CENTROIDS+1];
  logic  tok   [MAX_CENTROIDS+1];
  assign chain[0] = '{distance: '1, idx: '0};
  assign tok[0]   = go;

  genvar g;
  generate
    for (g = 0; g < MAX_CENTROIDS; g++) begin : g_cell
      logic signed [15:0] mem [RD];
      logic signed [15:0] rd;
      always_ff @(posedge clk) begin
        if (acc && op == OP_LOAD && lc == 8'(g)) begin
          mem[{ls, le}] <= sample;
        end
        rd <= mem[raddr];
      end
      pqe_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .step    (v1),
        .first   (first1),
        .enable  (9'(g) < cents),
        .index   (8'(g)),
        .diff    (17'(x1) - 17'(rd)),
        .best_in (chain[g]),
        .tok_in  (tok[g]),
        .best_out(chain[g+1]),
        .tok_out (tok[g+1])
      );
    end
  endgenerate

  // search control: start the token once the sums are final and the output
  // register is free, so the search never overtakes a held code
  logic [3:0] sp_s;
  logic       lsub_s;
  logic [7:0] bi;
  logic [3:0] bsp;
  logic       blast;

  always_ff @(posedge clk) begin
    if (rst) begin
      searching <= 1'b0;
      running   <= 1'b0;
      go        <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      go <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (vec_acc && last_elem) searching <= 1'b1;
      if (searching && !running && !m_tvalid) begin
        go      <= 1'b1;
        running <= 1'b1;
      end
      if (tok[MAX_CENTROIDS]) begin
        searching <= 1'b0;
        running   <= 1'b0;
        m_tvalid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vec_acc && last_elem) begin
      sp_s   <= subspace_position;
      lsub_s <= last_sub;
    end
    if (tok[MAX_CENTROIDS]) begin
      bi    <= chain[MAX_CENTROIDS].idx;
      bsp   <= sp_s;
      blast <= lsub_s;
    end
  end

  assign m_tdata = {4'd0, bsp, bi};
  assign m_tuser = blast;

`ifndef NO_ASSERTIONS
  a_no_accept_search: assert property (@(posedge clk) disable iff (rst)
    running |-> !s_tready) else $error("request taken during search");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("code dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable({m_tdata, m_tuser})) else $error("code changed");
`endif
endmodule
`default_nettype wire
